>>> rtl/core/scmd_pkg.sv
// ----------------------------------------------------------------------------
// Serial command line parser package
// Shared constants, register indexes, result kinds and the result word type.
// ----------------------------------------------------------------------------
package scmd_pkg;

  // Binary frame geometry.
  localparam int FRAME_BYTES    = 10;
  localparam int END_MARK_INDEX = 9;
  localparam int COMMAND_INDEX  = 1;
  localparam int FILL_W         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  // Text line buffer.
  localparam int LINE_BUFFER = 64;
  localparam int RAW_W       = $clog2(LINE_BUFFER);

  // Normalised text window.
  localparam int NORM_SLOTS = 5;
  localparam logic [2:0] NORM_SAT = 3'd6;
  localparam logic [2:0] NO_ZERO  = 3'd7;
  localparam logic [2:0] SET_LEN  = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_FRAME_START = 1'b0;
  localparam logic CFG_FRAME_END   = 1'b1;

  // Result kinds.
  localparam logic [2:0] KIND_BINARY      = 3'd0;
  localparam logic [2:0] KIND_SET_OUTPUT  = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN_CMD = 3'd2;
  localparam logic [2:0] KIND_INVALID_SET = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN_OUT = 3'd4;
  localparam logic [2:0] KIND_TOO_LONG    = 3'd5;

  // Output selections.
  localparam logic [2:0] SEL_OUT1 = 3'd0;
  localparam logic [2:0] SEL_OUT2 = 3'd1;
  localparam logic [2:0] SEL_OUT3 = 3'd2;
  localparam logic [2:0] SEL_5V   = 3'd3;
  localparam logic [2:0] SEL_BLUE = 3'd4;
  localparam logic [2:0] SEL_RED  = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // One result word.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] command_word;
    logic [2:0]  output_select;
    logic        output_level;
  } result_t;

endpackage

>>> rtl/core/serial_command_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Serial command line parser unit
// Takes received bytes, assembles binary command frames and text command
// lines, and gives one result word per finished frame or line.
// ----------------------------------------------------------------------------
// The byte that completes a frame or line is held in the input register; its
// result word is then loaded into the result register and offered on m_tvalid.
// Throughput: one byte per cycle; the input register keeps accepting while a
// result word waits, and stalls only when a second result meets a full
// result register. Reset clears the frame and line state, both registers and
// the configuration registers.
// ----------------------------------------------------------------------------
module serial_command_line_parser_unit
  import scmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata = rx_byte[7:0].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // Result stream: tuser = result_kind[2:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata = command_word[15:0], output_select[18:16], output_level[19], zero [23:20].
  output logic [23:0] m_tdata,
  output logic [2:0]  m_tuser,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic [7:0] frame_start_byte;
  logic [7:0] frame_end_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_word;
  logic       out_free;
  logic       advance;

  // The held byte moves on unless its result meets a full result register.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!res_valid || out_free);
  assign s_tready = !in_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start_byte <= '0;
      frame_end_byte   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_START: frame_start_byte <= cfg_data;
        CFG_FRAME_END:   frame_end_byte   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  scmd_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .rx_byte          (in_byte),
    .frame_start_byte (frame_start_byte),
    .frame_end_byte   (frame_end_byte),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tuser = out_word.kind;
  assign m_tdata = {4'b0000, out_word.output_level, out_word.output_select,
                    out_word.command_word};

endmodule

>>> rtl/core/scmd_engine.sv
// ----------------------------------------------------------------------------
// Serial command line parser engine
// Holds the frame and line state and works out, for the byte in hand, the
// next state and any result. State moves only when step is high.
// ----------------------------------------------------------------------------
module scmd_engine
  import scmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] frame_start_byte,
  input  logic [7:0] frame_end_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef struct packed {
    logic [NORM_SLOTS-1:0][7:0] chars;
    logic [2:0]                 count;
    logic [2:0]                 zpos;
  } norm_t;

  // Frame state.
  logic [FILL_W-1:0] frame_fill, frame_fill_next;
  logic [7:0]        frame_store [FRAME_BYTES];
  logic              store_first;

  // Line state.
  logic [RAW_W-1:0] raw_line_count, raw_line_count_next;
  logic             line_overflow, line_overflow_next;
  logic             gap_pending, gap_pending_next;
  norm_t            norm, norm_next;

  // Frame byte as seen once the byte in hand is stored; zero past the frame.
  function automatic logic [7:0] frame_byte(input int idx, input logic [FILL_W-1:0] fill,
                                            input logic [7:0] b);
    logic [7:0] v;
    v = CH_NUL;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == idx) begin
        v = (fill == FILL_W'(i)) ? b : frame_store[i];
      end
    end
    return v;
  endfunction

  // Append one character to the normalised window.
  function automatic norm_t norm_put(input norm_t s, input logic [7:0] c);
    norm_t r;
    r = s;
    if (c == CH_NUL && s.zpos == NO_ZERO && s.count < NORM_SAT) begin
      r.zpos = s.count;
    end
    for (int i = 0; i < NORM_SLOTS; i++) begin
      if (s.count == 3'(i)) begin
        r.chars[i] = c;
      end
    end
    if (s.count < NORM_SAT) begin
      r.count = s.count + 3'd1;
    end
    return r;
  endfunction

  // Classify a finished line.
  function automatic result_t finish_line(input norm_t s);
    result_t    r;
    logic [2:0] len;
    r = '0;
    len = (s.zpos != NO_ZERO) ? s.zpos : s.count;
    if (s.chars[0] != CH_S) begin
      r.kind = KIND_UNKNOWN_CMD;
    end else if (len != SET_LEN || s.chars[1] != CH_SPACE || s.chars[3] != CH_SPACE ||
                 (s.chars[4] != CH_0 && s.chars[4] != CH_1)) begin
      r.kind = KIND_INVALID_SET;
    end else begin
      r.kind = KIND_SET_OUTPUT;
      r.output_level = (s.chars[4] == CH_1);
      case (s.chars[2])
        CH_1:    r.output_select = SEL_OUT1;
        CH_2:    r.output_select = SEL_OUT2;
        CH_3:    r.output_select = SEL_OUT3;
        CH_5:    r.output_select = SEL_5V;
        CH_B:    r.output_select = SEL_BLUE;
        CH_R:    r.output_select = SEL_RED;
        default: begin
          r.kind = KIND_UNKNOWN_OUT;
          r.output_level = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // Next state and result for the byte in hand.
  always_comb begin
    logic [7:0] c;
    norm_t      n;
    frame_fill_next     = frame_fill;
    raw_line_count_next = raw_line_count;
    line_overflow_next  = line_overflow;
    gap_pending_next    = gap_pending;
    norm_next           = norm;
    store_first         = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;
    c                   = rx_byte;
    n                   = norm;

    if (frame_fill != '0) begin
      // Inside a frame every byte is data.
      if (frame_fill == FILL_W'(FRAME_BYTES - 1)) begin
        frame_fill_next = '0;
        if (frame_byte(0, frame_fill, rx_byte) == frame_start_byte &&
            frame_byte(END_MARK_INDEX, frame_fill, rx_byte) == frame_end_byte) begin
          res_valid        = 1'b1;
          res.kind         = KIND_BINARY;
          res.command_word = {frame_byte(COMMAND_INDEX, frame_fill, rx_byte),
                              frame_byte(COMMAND_INDEX + 1, frame_fill, rx_byte)};
        end
      end else begin
        frame_fill_next = frame_fill + FILL_W'(1);
      end
    end else if (rx_byte == frame_start_byte) begin
      // Frame start drops any partial line.
      store_first         = 1'b1;
      frame_fill_next     = FILL_W'(1);
      raw_line_count_next = '0;
      line_overflow_next  = 1'b0;
      gap_pending_next    = 1'b0;
      norm_next.count     = '0;
      norm_next.zpos      = NO_ZERO;
    end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      // End of line.
      if (line_overflow) begin
        res_valid = 1'b1;
        res.kind  = KIND_TOO_LONG;
      end else if (raw_line_count != '0 && norm.count != '0) begin
        res_valid = 1'b1;
        res       = finish_line(norm);
      end
      raw_line_count_next = '0;
      line_overflow_next  = 1'b0;
      gap_pending_next    = 1'b0;
      norm_next.count     = '0;
      norm_next.zpos      = NO_ZERO;
    end else if (!line_overflow) begin
      if (raw_line_count < RAW_W'(LINE_BUFFER - 1)) begin
        raw_line_count_next = raw_line_count + RAW_W'(1);
        if (rx_byte == CH_SPACE || rx_byte == CH_TAB) begin
          // Blanks fold into one pending gap, and leading blanks vanish.
          if (norm.count != '0) begin
            gap_pending_next = 1'b1;
          end
        end else begin
          if (gap_pending) begin
            n = norm_put(n, CH_SPACE);
            gap_pending_next = 1'b0;
          end
          if (rx_byte >= CH_LC_A && rx_byte <= CH_LC_Z) begin
            c = rx_byte - CASE_GAP;
          end
          norm_next = norm_put(n, c);
        end
      end else begin
        line_overflow_next = 1'b1;
      end
    end
  end

  // Control state and the normalised window.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_fill     <= '0;
      raw_line_count <= '0;
      line_overflow  <= 1'b0;
      gap_pending    <= 1'b0;
      norm.count     <= '0;
      norm.zpos      <= NO_ZERO;
    end else if (step) begin
      frame_fill     <= frame_fill_next;
      raw_line_count <= raw_line_count_next;
      line_overflow  <= line_overflow_next;
      gap_pending    <= gap_pending_next;
      norm.count     <= norm_next.count;
      norm.zpos      <= norm_next.zpos;
      norm.chars     <= norm_next.chars;
    end
  end

  // Frame payload store.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        if ((store_first && i == 0) || (frame_fill != '0 && frame_fill == FILL_W'(i))) begin
          frame_store[i] <= rx_byte;
        end
      end
    end
  end

endmodule

>>> rtl/core/scmd_checker.sv
// ----------------------------------------------------------------------------
// Serial command line parser port checker
// Watches the result stream of the top level and checks that each result
// word carries only the fields its kind allows.
// ----------------------------------------------------------------------------
module scmd_checker
  import scmd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // Result kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= KIND_TOO_LONG))
    else $error("undefined result kind");

  // Only a binary command carries a command word.
  a_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BINARY |-> m_tdata[15:0] == 16'h0000)
    else $error("command word set outside a binary command");

  // Only a set-output order carries a selection and a level.
  a_sel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_SET_OUTPUT |-> m_tdata[23:16] == 8'h00)
    else $error("output fields set outside a set-output order");

  // A set-output order names a real output.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SET_OUTPUT |-> m_tdata[18:16] <= SEL_RED)
    else $error("output selection out of range");

endmodule

bind serial_command_line_parser_unit scmd_checker u_scmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> sim/serial_command_line_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line parser unit testbench
// Drives received bytes into the parser with random gaps and random result
// back-pressure. A cycle-free predictor follows every accepted byte and
// queues the result word it expects. A checker compares each result word,
// field by field, with the oldest queued word. Directed tests cover binary
// frames, every set-output order and each error path, then random phases
// under several frame marker settings.
// ----------------------------------------------------------------------------
module serial_command_line_parser_unit_tb;
  import scmd_pkg::*;

  typedef logic [7:0] octet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // rx_byte[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // command_word[15:0], output_select[18:16], output_level[19]
  logic [2:0]  m_tuser;           // result_kind[2:0]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  serial_command_line_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the frame markers.
  octet_t start_mark = 8'h00;
  octet_t end_mark   = 8'h00;

  // Predictor copy of the frame and line state.
  int         frame_pos  = 0;
  octet_t     frame_bytes [FRAME_BYTES] = '{default: 8'h00};
  int         line_len   = 0;
  bit         line_full  = 1'b0;
  octet_t     text_chars [NORM_SLOTS] = '{default: 8'h00};
  logic [2:0] text_len   = 3'd0;
  bit         blank_seen = 1'b0;
  logic [2:0] nul_at     = NO_ZERO;

  result_t pending_results [$];
  octet_t  tx_line [$];
  int      bytes_sent   = 0;
  int      error_count  = 0;
  int      tx_gap_max   = 0;
  int      rx_stall_max = 0;
  int      rx_wait      = 0;
  result_t seen_word;
  result_t due_word;

  function automatic void drop_line();
    line_len   = 0;
    line_full  = 1'b0;
    text_len   = 3'd0;
    blank_seen = 1'b0;
    nul_at     = NO_ZERO;
  endfunction

  // Appends one character to the normalised text window.
  function automatic void put_text_char(input octet_t c);
    if (c == CH_NUL && nul_at == NO_ZERO && text_len < NORM_SAT) nul_at = text_len;
    if (text_len < NORM_SLOTS) text_chars[text_len] = c;
    if (text_len < NORM_SAT) text_len++;
  endfunction

  // Advances the predictor by one byte; returns 1 with the result word due.
  function automatic bit parse_rx_byte(input octet_t b, output result_t r);
    octet_t     c;
    logic [2:0] len;
    bit         got;
    r = '0;
    // Inside a frame every byte is frame data.
    if (frame_pos > 0) begin
      frame_bytes[frame_pos] = b;
      frame_pos++;
      if (frame_pos >= FRAME_BYTES) begin
        frame_pos = 0;
        if (frame_bytes[0] == start_mark && frame_bytes[END_MARK_INDEX] == end_mark) begin
          r.kind = KIND_BINARY;
          r.command_word = {frame_bytes[COMMAND_INDEX], frame_bytes[COMMAND_INDEX + 1]};
          return 1'b1;
        end
      end
      return 1'b0;
    end
    // A start byte drops the partial line and opens a frame.
    if (b == start_mark) begin
      drop_line();
      frame_bytes[0] = b;
      frame_pos = 1;
      return 1'b0;
    end
    // End of line: classify the normalised text.
    if (b == CH_CR || b == CH_LF) begin
      got = 1'b0;
      if (line_full) begin
        r.kind = KIND_TOO_LONG;
        got = 1'b1;
      end else if (line_len > 0 && text_len > 0) begin
        got = 1'b1;
        len = (nul_at != NO_ZERO) ? nul_at : text_len;
        if (text_chars[0] != CH_S) begin
          r.kind = KIND_UNKNOWN_CMD;
        end else if (len != SET_LEN || text_chars[1] != CH_SPACE ||
                     text_chars[3] != CH_SPACE ||
                     (text_chars[4] != CH_0 && text_chars[4] != CH_1)) begin
          r.kind = KIND_INVALID_SET;
        end else begin
          r.kind = KIND_SET_OUTPUT;
          r.output_level = (text_chars[4] == CH_1);
          case (text_chars[2])
            CH_1: r.output_select = SEL_OUT1;
            CH_2: r.output_select = SEL_OUT2;
            CH_3: r.output_select = SEL_OUT3;
            CH_5: r.output_select = SEL_5V;
            CH_B: r.output_select = SEL_BLUE;
            CH_R: r.output_select = SEL_RED;
            default: begin
              r.kind = KIND_UNKNOWN_OUT;
              r.output_level = 1'b0;
            end
          endcase
        end
      end
      drop_line();
      return got;
    end
    // Text byte: count it, then fold blanks and raise lower case.
    if (line_full) return 1'b0;
    if (line_len < LINE_BUFFER - 1) begin
      line_len++;
      if (b == CH_SPACE || b == CH_TAB) begin
        if (text_len > 0) blank_seen = 1'b1;
      end else begin
        if (blank_seen) begin
          put_text_char(CH_SPACE);
          blank_seen = 1'b0;
        end
        c = (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_GAP : b;
        put_text_char(c);
      end
    end else begin
      line_full = 1'b1;
    end
    return 1'b0;
  endfunction

  // Idle limit for a stretch of words: none, short or long gaps.
  function automatic int pick_idle_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  function automatic octet_t out_char(input int i);
    case (i)
      0: return CH_1;
      1: return CH_2;
      2: return CH_3;
      3: return CH_5;
      4: return CH_B;
      default: return CH_R;
    endcase
  endfunction

  // Result side: random stalls, and a check of every accepted word.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_word.kind          = m_tuser;
        seen_word.command_word  = m_tdata[15:0];
        seen_word.output_select = m_tdata[18:16];
        seen_word.output_level  = m_tdata[19];
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected word: kind %0d command %h select %0d level %0d",
                     seen_word.kind, seen_word.command_word,
                     seen_word.output_select, seen_word.output_level);
        end else begin
          due_word = pending_results.pop_front();
          if (seen_word !== due_word) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: exp kind %0d cmd %h sel %0d lvl %0d, got %0d %h %0d %0d",
                       due_word.kind, due_word.command_word, due_word.output_select,
                       due_word.output_level, seen_word.kind, seen_word.command_word,
                       seen_word.output_select, seen_word.output_level);
          end
        end
        if ($urandom_range(0, 31) == 0) rx_stall_max = pick_idle_limit();
        rx_wait = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  // Sends one byte after a random gap and predicts what it causes.
  task automatic send_byte(input octet_t b);
    int      gap;
    result_t want;
    if ($urandom_range(0, 31) == 0) tx_gap_max = pick_idle_limit();
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (parse_rx_byte(b, want)) pending_results.push_back(want);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (tx_line[i]) send_byte(tx_line[i]);
    tx_line.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic void add_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) tx_line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // One binary frame with random filler around the command word.
  task automatic send_frame(input logic [15:0] cmd, input octet_t close_b);
    for (int i = 0; i < FRAME_BYTES; i++) tx_line.push_back(octet_t'($urandom_range(0, 255)));
    tx_line[0] = start_mark;
    tx_line[COMMAND_INDEX] = cmd[15:8];
    tx_line[COMMAND_INDEX + 1] = cmd[7:0];
    tx_line[END_MARK_INDEX] = close_b;
    send_line();
  endtask

  // A set-output line with random layout and case, optionally damaged.
  task automatic send_set_line(input octet_t which, input bit level, input bit damage);
    int pos;
    add_blanks(0, 2);
    tx_line.push_back($urandom_range(0, 1) ? CH_S : CH_S + CASE_GAP);
    add_blanks(1, 3);
    tx_line.push_back((which >= CH_B && which <= CH_R && $urandom_range(0, 1)) ?
                      which + CASE_GAP : which);
    add_blanks(1, 3);
    tx_line.push_back(level ? CH_1 : CH_0);
    add_blanks(0, 2);
    if (damage) begin
      pos = $urandom_range(0, tx_line.size() - 1);
      case ($urandom_range(0, 3))
        0: tx_line[pos] = octet_t'($urandom_range(0, 255));
        1: tx_line.insert(pos, octet_t'($urandom_range(32, 126)));
        2: tx_line.delete(pos);
        default: tx_line.insert(pos, CH_NUL);
      endcase
    end
    tx_line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    send_line();
  endtask

  // Waits until every expected word has arrived and the pipeline is empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic which_reg, input octet_t value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= which_reg;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which_reg == CFG_FRAME_START) start_mark = value;
    else end_mark = value;
  endtask

  // Markers at their reset value of zero: a zero byte opens a frame.
  task automatic test_reset_markers();
    send_frame(16'h1234, 8'h00);
    send_text("s r 1\r");
  endtask

  task automatic test_binary_frames();
    write_reg(CFG_FRAME_START, 8'hAA);
    write_reg(CFG_FRAME_END, 8'h55);
    send_frame(16'h0000, end_mark);
    send_frame(16'hFFFF, end_mark);
    // CR, LF and the start byte itself as frame data.
    send_frame(16'h0D0A, end_mark);
    send_frame(16'hAAAA, end_mark);
    // Wrong end marker closes the frame silently.
    send_frame(16'h1234, ~end_mark);
    // A frame drops the partial line, so the CR after it ends an empty line.
    send_text("S 1");
    send_frame(16'hBEEF, end_mark);
    send_text("\r");
  endtask

  task automatic test_set_orders();
    for (int i = 0; i < 12; i++) send_set_line(out_char(i / 2), bit'(i % 2), 1'b0);
    send_text("   S  1\t\t1 \r");
  endtask

  task automatic test_line_errors();
    send_text("X\r");
    send_text("s\r");
    send_text("S 1 2\r");
    send_text("S1 1\r");
    send_text("S 11 1\r");
    send_text("S 4 1\r");
    // Empty and blank-only lines give nothing.
    send_text("\r");
    send_text(" \t \n");
    // A zero byte ends the text for the set test.
    send_text("S 1 1");
    send_byte(CH_NUL);
    send_text("X\r");
    send_byte(CH_NUL);
    send_text("S 1 1\r");
    send_text("S 1");
    send_byte(CH_NUL);
    send_text(" 1\r");
  endtask

  task automatic test_long_lines();
    repeat (LINE_BUFFER - 1) send_byte(CH_B);
    send_text("\r");
    repeat (LINE_BUFFER) send_byte(CH_B);
    send_text("\r");
    send_text("S 1 1");
    repeat (LINE_BUFFER + 6) send_byte(CH_SPACE);
    send_text("\n");
    send_text("S 2 0\r");
  endtask

  // The start marker changes while a frame is open, so its first byte is stale.
  task automatic test_start_change_mid_frame();
    send_byte(start_mark);
    repeat (4) send_byte(octet_t'($urandom_range(0, 255)));
    write_reg(CFG_FRAME_START, 8'h3C);
    repeat (FRAME_BYTES - 6) send_byte(octet_t'($urandom_range(0, 255)));
    send_byte(end_mark);
    send_frame(16'hC3A5, end_mark);
  endtask

  // Mostly well-formed lines and frames, with damaged lines and noise.
  task automatic random_phase(input octet_t start_b, input octet_t end_b, input int n);
    int first;
    int pick;
    write_reg(CFG_FRAME_START, start_b);
    write_reg(CFG_FRAME_END, end_b);
    first = bytes_sent;
    while (bytes_sent - first < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_set_line(($urandom_range(0, 6) == 0) ? octet_t'($urandom_range(32, 126)) :
                      out_char($urandom_range(0, 5)), bit'($urandom_range(0, 1)), pick >= 8);
      end else if (pick < 16) begin
        send_frame(16'($urandom_range(0, 65535)), ($urandom_range(0, 4) == 0) ?
                   octet_t'($urandom_range(0, 255)) : end_mark);
      end else if (pick < 19) begin
        repeat ($urandom_range(0, 12))
          tx_line.push_back(($urandom_range(0, 7) == 0) ? start_mark :
                            octet_t'($urandom_range(0, 255)));
        tx_line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        send_line();
      end else begin
        repeat ($urandom_range(LINE_BUFFER - 8, LINE_BUFFER + 16))
          tx_line.push_back(octet_t'($urandom_range(32, 126)));
        tx_line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        send_line();
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(8'hFF, 8'h00, 240);
    random_phase(8'h00, 8'hFF, 240);
    random_phase(octet_t'($urandom_range(0, 255)), octet_t'($urandom_range(0, 255)), 240);
    random_phase(octet_t'($urandom_range(128, 255)), octet_t'($urandom_range(0, 255)), 240);
  endtask

  // Test sequence.
  initial begin
    tx_gap_max   = pick_idle_limit();
    rx_stall_max = pick_idle_limit();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_markers();
    test_binary_frames();
    test_set_orders();
    test_line_errors();
    test_long_lines();
    test_start_change_mid_frame();
    test_random_traffic();
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/scmd_pkg.sv
rtl/core/scmd_engine.sv
rtl/core/serial_command_line_parser_unit.sv
rtl/core/scmd_checker.sv
sim/serial_command_line_parser_unit_tb.sv
